// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TSIW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define TSIW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/tsiw_pkg.sv
package tsiw_pkg;

    localparam int COEF_SLOTS = 12;
    localparam int NIB_W      = 4;
    localparam int VAL_W      = 6;
    localparam int WID_W      = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES4  = 8'd1;

    typedef logic [NIB_W-1:0] nib_t;

    typedef enum logic [2:0] {
        FLD_COUNT,
        FLD_RES,
        FLD_LEN,
        FLD_ORD,
        FLD_DIR,
        FLD_COMP,
        FLD_COEF
    } fld_t;

    typedef struct packed {
        logic short_win;
        logic res4;
    } cfg_t;

    typedef struct packed {
        logic in_band;
        nib_t val_plain;
        nib_t val_comp;
    } lane_res_t;

    typedef struct packed {
        logic                    is_filter;
        logic [1:0]              cnt_val;
        logic                    cnt_nz;
        logic [5:0]              len_val;
        logic [3:0]              ord;
        logic                    dir;
        logic                    comp;
        nib_t [COEF_SLOTS-1:0]   coef;
    } item_t;

endpackage

// File: hw/rtl/tsiw_lane.sv
module tsiw_lane (
    input  tsiw_pkg::nib_t      nib,
    input  logic                res4,
    output tsiw_pkg::lane_res_t res
);
    import tsiw_pkg::*;

    nib_t v;
    nib_t lo_idx;
    nib_t hi_idx;
    nib_t down_step;

    always_comb begin
        v         = res4 ? nib : {1'b0, nib[NIB_W-2:0]};
        lo_idx    = res4 ? 4'd4  : 4'd2;
        hi_idx    = res4 ? 4'd11 : 4'd5;
        down_step = res4 ? 4'd8  : 4'd4;
        res.in_band   = (v >= lo_idx) && (v <= hi_idx);
        res.val_plain = v;
        // Only indices above the middle band move down when compressed.
        res.val_comp  = (v > hi_idx) ? v - down_step : v;
    end

endmodule

// File: hw/rtl/tsiw_emit.sv
module tsiw_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tsiw_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tsiw_pkg::item_t               in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tsiw_pkg::VAL_W-1:0]    out_value,
    output logic [tsiw_pkg::WID_W-1:0]    out_width,
    output logic                          out_last
);
    import tsiw_pkg::*;

    fld_t              state_reg, state_next;
    logic [3:0]        idx_reg, idx_next;
    logic              busy_reg, busy_next;
    item_t             item_reg;
    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_value_reg;
    logic [WID_W-1:0]  m_width_reg;
    logic              m_last_reg;

    logic [VAL_W-1:0]  fld_val;
    logic [WID_W-1:0]  fld_wid;
    logic              fld_last;
    nib_t              coef_cur;
    logic [WID_W-1:0]  clen;
    logic              out_load;
    logic              take;

    assign out_load = busy_reg && (!m_valid_reg || out_ready);
    assign in_ready = !busy_reg || (out_load && fld_last);
    assign take     = in_valid && in_ready;

    assign coef_cur = item_reg.coef[idx_reg];

    // Field produced by the current state.
    always_comb begin
        fld_val  = '0;
        fld_wid  = 3'd1;
        fld_last = 1'b0;
        clen     = cfg.res4 ? (item_reg.comp ? 3'd3 : 3'd4)
                            : (item_reg.comp ? 3'd2 : 3'd3);
        unique case (state_reg)
            FLD_COUNT: begin
                fld_val  = {4'd0, item_reg.cnt_val};
                fld_wid  = cfg.short_win ? 3'd1 : 3'd2;
                fld_last = !item_reg.cnt_nz;
            end
            FLD_RES: begin
                fld_val  = {5'd0, cfg.res4};
                fld_last = 1'b1;
            end
            FLD_LEN: begin
                fld_val = item_reg.len_val;
                fld_wid = cfg.short_win ? 3'd4 : 3'd6;
            end
            FLD_ORD: begin
                fld_val  = {2'd0, item_reg.ord};
                fld_wid  = cfg.short_win ? 3'd3 : 3'd5;
                fld_last = (item_reg.ord == 4'd0);
            end
            FLD_DIR: begin
                fld_val = {5'd0, item_reg.dir};
            end
            FLD_COMP: begin
                fld_val = {5'd0, item_reg.comp};
            end
            FLD_COEF: begin
                case (clen)
                    3'd2:    fld_val = {4'd0, coef_cur[1:0]};
                    3'd3:    fld_val = {3'd0, coef_cur[2:0]};
                    default: fld_val = {2'd0, coef_cur};
                endcase
                fld_wid  = clen;
                fld_last = (idx_reg == item_reg.ord - 4'd1);
            end
            default: begin
                fld_val  = '0;
                fld_wid  = 3'd1;
                fld_last = 1'b1;
            end
        endcase
    end

    // Sequencing through the fields of one item.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        if (out_load) begin
            if (fld_last) begin
                busy_next = 1'b0;
            end else begin
                unique case (state_reg)
                    FLD_COUNT: state_next = FLD_RES;
                    FLD_LEN:   state_next = FLD_ORD;
                    FLD_ORD:   state_next = FLD_DIR;
                    FLD_DIR:   state_next = FLD_COMP;
                    FLD_COMP: begin
                        state_next = FLD_COEF;
                        idx_next   = 4'd0;
                    end
                    FLD_COEF:  idx_next = idx_reg + 4'd1;
                    default:   state_next = state_reg;
                endcase
            end
        end
        if (take) begin
            busy_next  = 1'b1;
            state_next = in_item.is_filter ? FLD_LEN : FLD_COUNT;
            idx_next   = 4'd0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FLD_COUNT;
            idx_reg     <= 4'd0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= in_item;
        end
        if (out_load) begin
            m_value_reg <= fld_val;
            m_width_reg <= fld_wid;
            m_last_reg  <= fld_last;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_value = m_value_reg;
    assign out_width = m_width_reg;
    assign out_last  = m_last_reg;

endmodule

// File: hw/rtl/tns_side_info_writer.sv
// TNS side-information writer. Each input item becomes a run of bitstream
// fields, one field per cycle on the result channel when not back-pressured,
// tlast on the last one. A window-start item gives 1 or 2 fields, a filter
// item 2 to 16 (length, order, direction, compression flag, then one field
// per coefficient); the field sequencer is the rate limit. Twelve coefficient
// lanes check the band and form the compressed indices in the cycle an item
// is accepted, and the next item is accepted in the same cycle as the last
// field of the current one is loaded into the output register. Configuration
// must be written by the user only while the block idles (not enforced).
module tns_side_info_writer #(
    parameter int MAX_ORDER = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // filter_count[1:0], region_length[7:2], filter_order[11:8],
    // direction[12], coef_indices[60:13], zero[63:61]
    input  logic [63:0] s_tdata,
    // action[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // field_value[5:0], field_width[8:6], zero[15:9]
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_wvalid,
    output logic        cfg_wready,
    input  logic [7:0]  cfg_windex,
    input  logic [7:0]  cfg_wdata
);
    import tsiw_pkg::*;

    localparam int ORD_CAP = (MAX_ORDER < COEF_SLOTS) ? MAX_ORDER : COEF_SLOTS;
    localparam int ORD_CAP_SHORT = (ORD_CAP < 7) ? ORD_CAP : 7;
    localparam logic [3:0] ORD_TOP_LONG  = 4'(ORD_CAP);
    localparam logic [3:0] ORD_TOP_SHORT = 4'(ORD_CAP_SHORT);

    logic short_reg;
    logic res4_reg;
    cfg_t cfg;

    logic [1:0]              in_cnt;
    logic [5:0]              in_len;
    logic [3:0]              in_ord;
    logic [3:0]              ord_top;
    logic [3:0]              ord_sat;
    nib_t [COEF_SLOTS-1:0]   in_coef;
    lane_res_t [COEF_SLOTS-1:0] lane_res;
    logic                    comp;
    item_t                   item;

    logic              emit_out_valid;
    logic [VAL_W-1:0]  emit_value;
    logic [WID_W-1:0]  emit_width;
    logic              emit_last;

    assign cfg_wready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_reg <= 1'b0;
            res4_reg  <= 1'b1;
        end else if (cfg_wvalid) begin
            unique case (cfg_windex)
                CFG_SHORT: short_reg <= cfg_wdata[0];
                CFG_RES4:  res4_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg.short_win = short_reg;
    assign cfg.res4      = res4_reg;

    assign in_cnt  = s_tdata[1:0];
    assign in_len  = s_tdata[7:2];
    assign in_ord  = s_tdata[11:8];
    assign in_coef = s_tdata[60:13];

    assign ord_top = short_reg ? ORD_TOP_SHORT : ORD_TOP_LONG;
    assign ord_sat = (in_ord > ord_top) ? ord_top : in_ord;

    genvar g;
    generate
        for (g = 0; g < COEF_SLOTS; g++) begin : g_lane
            tsiw_lane u_lane (
                .nib  (in_coef[g]),
                .res4 (res4_reg),
                .res  (lane_res[g])
            );
        end
    endgenerate

    // Merge: compression holds only when no used index is in the middle band.
    always_comb begin
        comp = 1'b1;
        for (int i = 0; i < COEF_SLOTS; i++) begin
            if (lane_res[i].in_band && (4'(i) < ord_sat)) begin
                comp = 1'b0;
            end
        end
    end

    always_comb begin
        item.is_filter = s_tuser[0];
        item.cnt_nz    = (in_cnt != 2'd0);
        item.cnt_val   = short_reg ? {1'b0, item.cnt_nz} : in_cnt;
        item.len_val   = (short_reg && (in_len > 6'd15)) ? 6'd15 : in_len;
        item.ord       = ord_sat;
        item.dir       = s_tdata[12];
        item.comp      = comp;
        for (int i = 0; i < COEF_SLOTS; i++) begin
            item.coef[i] = comp ? lane_res[i].val_comp : lane_res[i].val_plain;
        end
    end

    tsiw_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (emit_out_valid),
        .out_ready (m_tready),
        .out_value (emit_value),
        .out_width (emit_width),
        .out_last  (emit_last)
    );

    assign m_tvalid = emit_out_valid;
    assign m_tdata  = {7'd0, emit_width, emit_value};
    assign m_tlast  = emit_last;

endmodule

// File: hw/rtl/tsiw_checker.sv
`include "assert_macros.svh"

module tsiw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result keeps its contents.
    `TSIW_ASSERT(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result changed")

    // Every field carries one to six bits.
    `TSIW_ASSERT(a_width, aclk, aresetn, m_tvalid |-> ((m_tdata[8:6] != 3'd0) && (m_tdata[8:6] != 3'd7)), "field width out of range")

    // The value never has bits above its width.
    `TSIW_ASSERT(a_fits, aclk, aresetn, (m_tvalid && (m_tdata[8:6] != 3'd6)) |-> ((m_tdata[5:0] >> m_tdata[8:6]) == 6'd0), "field value wider than its width")

    // Reset empties the output register.
    `TSIW_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind tns_side_info_writer tsiw_checker u_tsiw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
